// ----- design/cyclic_code_systematic_codec_unit_defines.svh -----
// Assertion macros used by the codec RTL.
`ifndef CYCLIC_CODE_SYSTEMATIC_CODEC_UNIT_DEFINES_SVH
`define CYCLIC_CODE_SYSTEMATIC_CODEC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Implication checked in the same cycle.
`define CSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication checked in the next cycle.
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSC_ASSERT_NOW(lbl, ante, cons, msg)
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/cscodec_pkg.sv -----
package cscodec_pkg;

	// Size limits of the code.
	localparam int MAX_CODE_BITS  = 64;
	localparam int MAX_CHECK_BITS = 8;

	// Register field widths and the configuration bus.
	localparam int GEN_W  = 9;
	localparam int CHK_W  = 4;
	localparam int MSG_W  = 6;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register reset values: x^3 + x + 1 with four message bits.
	localparam logic [GEN_W-1:0] GEN_RESET = 9'd11;
	localparam logic [CHK_W-1:0] CHK_RESET = 4'd3;
	localparam logic [MSG_W-1:0] MSG_RESET = 6'd4;

	// Register indexes on the configuration bus.
	typedef enum logic [1:0] {
		REG_GEN = 2'd0,
		REG_CHK = 2'd1,
		REG_MSG = 2'd2
	} reg_idx_t;

	// Configuration register contents.
	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [CHK_W-1:0] chk;
		logic [MSG_W-1:0] msg;
	} cfg_t;

	// Operation kind of an input item.
	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_CLEAN         = 2'd0,
		STATUS_CORRECTED     = 2'd1,
		STATUS_UNCORRECTABLE = 2'd2
	} status_t;

	// Operations of the remainder cells.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DIVIDE,
		CELL_ROTATE
	} cell_op_t;

	// Control shared by every cell of the remainder chain.
	typedef struct packed {
		cell_op_t op;
		logic     fb_s;
		logic     fb_e;
		logic     wrap;
	} cell_ctrl_t;

endpackage

// ----- design/cscodec_cell.sv -----
// One stage of the remainder chain. It holds one bit of the syndrome and one
// bit of the wrap term (x^n mod g), and takes the bits of its lower neighbor.
module cscodec_cell (
	input  logic                    clk,
	input  cscodec_pkg::cell_ctrl_t ctrl,
	input  logic                    active,
	input  logic                    g_bit,
	input  logic                    seed,
	input  logic                    s_prev,
	input  logic                    e_prev,
	output logic                    s_bit,
	output logic                    e_bit
);

	logic s_q;
	logic e_q;

	// Shift with generator feedback; a rotation also folds in x^n + 1.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			cscodec_pkg::CELL_HOLD: begin
				s_q <= s_q;
			end
			cscodec_pkg::CELL_CLEAR: begin
				s_q <= 1'b0;
				e_q <= seed;
			end
			cscodec_pkg::CELL_DIVIDE: begin
				s_q <= active & (s_prev ^ (ctrl.fb_s & g_bit));
				e_q <= active & (e_prev ^ (ctrl.fb_e & g_bit));
			end
			cscodec_pkg::CELL_ROTATE: begin
				s_q <= active & (s_prev ^ (ctrl.fb_s & g_bit) ^ (ctrl.wrap & (e_q ^ seed)));
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

	assign s_bit = s_q;
	assign e_bit = e_q;

endmodule

// ----- design/cscodec_cfg.sv -----
// Configuration registers behind the APB-style port.
module cscodec_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cscodec_pkg::ADDR_W-1:0] paddr,
	input  logic [cscodec_pkg::DATA_W-1:0] pwdata,
	output logic [cscodec_pkg::DATA_W-1:0] prdata,
	output logic                           pready,
	output cscodec_pkg::cfg_t              cfg
);

	cscodec_pkg::cfg_t     cfg_q;
	cscodec_pkg::reg_idx_t idx;

	assign idx    = cscodec_pkg::reg_idx_t'(paddr[cscodec_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen <= cscodec_pkg::GEN_RESET;
			cfg_q.chk <= cscodec_pkg::CHK_RESET;
			cfg_q.msg <= cscodec_pkg::MSG_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				cscodec_pkg::REG_GEN: cfg_q.gen <= pwdata[cscodec_pkg::GEN_W-1:0];
				cscodec_pkg::REG_CHK: cfg_q.chk <= pwdata[cscodec_pkg::CHK_W-1:0];
				cscodec_pkg::REG_MSG: cfg_q.msg <= pwdata[cscodec_pkg::MSG_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (idx)
			cscodec_pkg::REG_GEN: prdata = cscodec_pkg::DATA_W'(cfg_q.gen);
			cscodec_pkg::REG_CHK: prdata = cscodec_pkg::DATA_W'(cfg_q.chk);
			cscodec_pkg::REG_MSG: prdata = cscodec_pkg::DATA_W'(cfg_q.msg);
			default:              prdata = '0;
		endcase
	end

endmodule

// ----- design/cyclic_code_systematic_codec_unit.sv -----
// Systematic cyclic code encoder and single-error-trapping decoder. A start
// pulse while busy is low takes one item; exactly one result follows, shown
// for one cycle with done high, and the receiver cannot stall it, so it must
// take every result in that cycle. With n = k + r code bits, an encode or a
// decode with a clean syndrome ends when the division of the n code bits is
// done and busy falls as the result is shown; a decode with another syndrome
// then rotates the word until a weight-one syndrome traps the error, which
// ST_FIX corrects, or until the last rotation leaves it uncorrectable. A new
// start is taken once busy is low again. The chain of remainder cells divides
// by the generator one codeword bit per cycle and then steps the syndrome of
// the rotated word one rotation per cycle.
// busy falls in the same cycle that done is shown, so the next start may meet
// the result.
`include "cyclic_code_systematic_codec_unit_defines.svh"

module cyclic_code_systematic_codec_unit #(
	parameter int MAX_CODE_BITS  = cscodec_pkg::MAX_CODE_BITS,
	parameter int MAX_CHECK_BITS = cscodec_pkg::MAX_CHECK_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic                           kind,
	input  logic [MAX_CODE_BITS-1:0]       word_in,
	output logic [MAX_CODE_BITS-1:0]       word_out,
	output logic [1:0]                     status,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cscodec_pkg::ADDR_W-1:0] paddr,
	input  logic [cscodec_pkg::DATA_W-1:0] pwdata,
	output logic [cscodec_pkg::DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int N     = MAX_CODE_BITS;
	localparam int R     = MAX_CHECK_BITS;
	localparam int NW    = $clog2(N + 1);
	localparam int CW    = $clog2(N);
	localparam int RW    = $clog2(R + 1);
	localparam int RIW   = $clog2(R);
	localparam int R_CAP = (R < N - 1) ? R : N - 1;
	localparam int SL    = (R < N) ? R : N;
	localparam int GW    = cscodec_pkg::GEN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_FIX
	} state_t;

	cscodec_pkg::cfg_t       cfg;
	cscodec_pkg::cell_ctrl_t cell_ctrl;
	cscodec_pkg::status_t    status_q;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   pos_q;
	logic            done_q;
	logic [N-1:0]    word_out_q;
	logic [N-1:0]    c_q;
	logic [RW-1:0]   r_q;
	logic [NW-1:0]   n_q;
	logic [R-1:0]    act_q;
	logic [R-1:0]    g_q;
	logic            kind_q;

	logic [cscodec_pkg::CHK_W-1:0] r_lo;
	logic [cscodec_pkg::MSG_W-1:0] k_lo;
	logic [RW-1:0]   r_eff;
	logic [NW-1:0]   k_cap;
	logic [NW-1:0]   k_eff;
	logic [NW-1:0]   n_eff;
	logic [NW-1:0]   n_m1;
	logic [N-1:0]    mask_n;
	logic [N-1:0]    mask_k;
	logic [N-1:0]    c_in;
	logic [R-1:0]    act_in;
	logic [R+GW-1:0] gen_ext;
	logic            accept;

	logic [R-1:0]    s_vec;
	logic [R-1:0]    e_vec;
	logic [R-1:0]    s_prev;
	logic [R-1:0]    e_prev;
	logic [RW-1:0]   r_m1;
	logic            s_zero;
	logic            s_clean;
	logic            s_one;
	logic [RIW-1:0]  j_idx;
	logic [NW-1:0]   d_ext;
	logic [NW-1:0]   j_ext;
	logic [NW-1:0]   pos_calc;
	logic [NW-1:0]   wrap_idx;
	logic            last_rot;
	logic            scan_rotate;
	logic            feed;
	logic [N-1:0]    s_ext;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Configuration registers.
	cscodec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Effective check and message lengths after clamping.
	always_comb begin
		r_lo = (cfg.chk == '0) ? cscodec_pkg::CHK_W'(1) : cfg.chk;
		k_lo = (cfg.msg == '0) ? cscodec_pkg::MSG_W'(1) : cfg.msg;
		if (32'(r_lo) > 32'(R_CAP)) begin
			r_eff = RW'(R_CAP);
		end else begin
			r_eff = RW'(r_lo);
		end
		k_cap = NW'(N) - NW'(r_eff);
		if (32'(k_lo) > 32'(k_cap)) begin
			k_eff = k_cap;
		end else begin
			k_eff = NW'(k_lo);
		end
		n_eff  = k_eff + NW'(r_eff);
		n_m1   = n_eff - NW'(1);
		mask_n = ~({N{1'b1}} << n_eff);
		mask_k = ~({N{1'b1}} << k_eff);
		if (kind == cscodec_pkg::KIND_ENCODE) begin
			c_in = (word_in & mask_k) << r_eff;
		end else begin
			c_in = word_in & mask_n;
		end
		for (int i = 0; i < R; i++) begin
			act_in[i] = (32'(i) < 32'(r_eff));
		end
		gen_ext = (R + GW)'(cfg.gen);
	end

	// Item operands, captured on the accepting edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q    <= c_in;
			r_q    <= r_eff;
			n_q    <= n_eff;
			act_q  <= act_in;
			g_q    <= gen_ext[R-1:0] & act_in;
			kind_q <= kind;
		end
	end

	// Syndrome decode: weight-one test and position of the trapped bit.
	// A zero syndrome means a clean word only before any rotation.
	always_comb begin
		r_m1    = r_q - RW'(1);
		s_zero  = (s_vec == '0);
		s_clean = s_zero && (cnt_q == '0);
		s_one   = !s_zero && ((s_vec & (s_vec - R'(1))) == '0);
		j_idx  = '0;
		for (int i = 0; i < R; i++) begin
			if (s_vec[i]) begin
				j_idx = RIW'(i);
			end
		end
		d_ext = NW'(cnt_q);
		j_ext = NW'(j_idx);
		if (j_ext >= d_ext) begin
			pos_calc = j_ext - d_ext;
		end else begin
			pos_calc = j_ext + n_q - d_ext;
		end
		wrap_idx    = n_q - NW'(1) - d_ext;
		last_rot    = (d_ext == n_q - NW'(1));
		scan_rotate = (state_q == ST_SCAN) && (kind_q == cscodec_pkg::KIND_DECODE)
			&& !s_clean && !s_one && !last_rot;
		s_ext       = '0;
		s_ext[SL-1:0] = s_vec[SL-1:0];
	end

	// Control of the cell chain.
	always_comb begin
		cell_ctrl.fb_s = s_vec[r_m1[RIW-1:0]];
		cell_ctrl.fb_e = e_vec[r_m1[RIW-1:0]];
		cell_ctrl.wrap = c_q[wrap_idx[CW-1:0]];
		feed           = 1'b0;
		if (accept) begin
			cell_ctrl.op = cscodec_pkg::CELL_CLEAR;
		end else if (state_q == ST_DIV) begin
			cell_ctrl.op = cscodec_pkg::CELL_DIVIDE;
			feed         = c_q[cnt_q];
		end else if (scan_rotate) begin
			cell_ctrl.op = cscodec_pkg::CELL_ROTATE;
		end else begin
			cell_ctrl.op = cscodec_pkg::CELL_HOLD;
		end
	end

	assign s_prev = {s_vec[R-2:0], feed};
	assign e_prev = {e_vec[R-2:0], 1'b0};

	// Row of remainder cells, one per check bit.
	for (genvar i = 0; i < R; i++) begin : g_cell
		cscodec_cell u_cell (
			.clk    (clk),
			.ctrl   (cell_ctrl),
			.active (act_q[i]),
			.g_bit  (g_q[i]),
			.seed   (i == 0),
			.s_prev (s_prev[i]),
			.e_prev (e_prev[i]),
			.s_bit  (s_vec[i]),
			.e_bit  (e_vec[i])
		);
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pos_q      <= '0;
			done_q     <= 1'b0;
			word_out_q <= '0;
			status_q   <= cscodec_pkg::STATUS_CLEAN;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						cnt_q   <= n_m1[CW-1:0];
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SCAN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_SCAN: begin
					priority if (kind_q == cscodec_pkg::KIND_ENCODE) begin
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						word_out_q <= c_q | s_ext;
						status_q   <= cscodec_pkg::STATUS_CLEAN;
					end else if (s_clean) begin
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						word_out_q <= c_q >> r_q;
						status_q   <= cscodec_pkg::STATUS_CLEAN;
					end else if (s_one) begin
						state_q <= ST_FIX;
						pos_q   <= pos_calc[CW-1:0];
					end else if (last_rot) begin
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						word_out_q <= c_q >> r_q;
						status_q   <= cscodec_pkg::STATUS_UNCORRECTABLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_FIX: begin
					state_q    <= ST_IDLE;
					done_q     <= 1'b1;
					word_out_q <= (c_q ^ (N'(1) << pos_q)) >> r_q;
					status_q   <= cscodec_pkg::STATUS_CORRECTED;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign word_out = word_out_q;
	assign status   = status_q;

	// A result transfer always coincides with the block going idle.
	`CSC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
	// An accepted item keeps the block busy and yields no result next cycle.
	`CSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not start work")
	// Encoding never reports an error status.
	`CSC_ASSERT_NOW(a_enc_clean, done && (kind_q == cscodec_pkg::KIND_ENCODE), status_q == cscodec_pkg::STATUS_CLEAN, "encode result with error status")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int MAX_CODE_BITS  = cscodec_pkg::MAX_CODE_BITS;
	localparam int MAX_CHECK_BITS = cscodec_pkg::MAX_CHECK_BITS;
	localparam int ADDR_W         = cscodec_pkg::ADDR_W;
	localparam int DATA_W         = cscodec_pkg::DATA_W;
	localparam int GEN_W          = cscodec_pkg::GEN_W;
	localparam int CHK_W          = cscodec_pkg::CHK_W;
	localparam int MSG_W          = cscodec_pkg::MSG_W;

	// One predicted result of the codec.
	typedef struct packed {
		logic [MAX_CODE_BITS-1:0] word;
		cscodec_pkg::status_t     outcome;
	} codec_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start;
	logic                     busy;
	logic                     done;
	logic                     kind;
	logic [MAX_CODE_BITS-1:0] word_in;
	logic [MAX_CODE_BITS-1:0] word_out;
	logic [1:0]               status;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]        pwdata;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	// Register contents as the block should hold them.
	cscodec_pkg::cfg_t active_cfg = '{gen: cscodec_pkg::GEN_RESET,
		chk: cscodec_pkg::CHK_RESET, msg: cscodec_pkg::MSG_RESET};
	codec_result_t expected_results[$];
	int            mismatch_count = 0;
	int            sender_idle_pct = 23;

	cyclic_code_systematic_codec_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.done     (done),
		.kind     (kind),
		.word_in  (word_in),
		.word_out (word_out),
		.status   (status),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// Mask of the w lowest bits.
	function automatic logic [MAX_CODE_BITS-1:0] ones_below(int w);
		return (w >= MAX_CODE_BITS) ? {MAX_CODE_BITS{1'b1}} : ((64'd1 << w) - 64'd1);
	endfunction

	// Check bits r and message bits k after the block's clamping.
	function automatic void clamp_sizes(input cscodec_pkg::cfg_t c, output int r,
			output int k);
		r = int'(c.chk);
		if (r < 1) r = 1;
		if (r > MAX_CHECK_BITS) r = MAX_CHECK_BITS;
		if (r > MAX_CODE_BITS - 1) r = MAX_CODE_BITS - 1;
		k = int'(c.msg);
		if (k < 1) k = 1;
		if (k > MAX_CODE_BITS - r) k = MAX_CODE_BITS - r;
	endfunction

	// Remainder of an n-bit word modulo the degree-r generator over GF(2).
	function automatic logic [MAX_CODE_BITS-1:0] gf2_remainder(logic [MAX_CODE_BITS-1:0] w,
			int n, int r, logic [MAX_CODE_BITS-1:0] g);
		for (int i = n - 1; i >= r; i--)
			if (w[i]) w ^= g << (i - r);
		return w & ones_below(r);
	endfunction

	// Encode, or decode with error trapping, under configuration c.
	function automatic codec_result_t predict_codec_result(cscodec_pkg::cfg_t c, logic op,
			logic [MAX_CODE_BITS-1:0] din);
		int                       r;
		int                       k;
		int                       n;
		logic [MAX_CODE_BITS-1:0] g;
		logic [MAX_CODE_BITS-1:0] mask;
		logic [MAX_CODE_BITS-1:0] cw;
		logic [MAX_CODE_BITS-1:0] syn;
		logic [MAX_CODE_BITS-1:0] w;
		codec_result_t            res;
		clamp_sizes(c, r, k);
		n = r + k;
		mask = ones_below(n);
		// Only the low r generator bits count; the top coefficient is implied.
		g = (64'(c.gen) & ones_below(r)) | (64'd1 << r);
		res.outcome = cscodec_pkg::STATUS_CLEAN;
		if (op == cscodec_pkg::KIND_ENCODE) begin
			cw = (din & ones_below(k)) << r;
			res.word = cw | gf2_remainder(cw, n, r, g);
			return res;
		end
		cw = din & mask;
		syn = gf2_remainder(cw, n, r, g);
		res.word = cw >> r;
		if (syn == 0) return res;
		// Rotate toward higher degree until the syndrome has a single bit set.
		w = cw;
		for (int d = 0; d < n; d++) begin
			if (syn != 0 && (syn & (syn - 64'd1)) == 0) begin
				w ^= syn;
				for (int j = 0; j < d; j++)
					w = ((w >> 1) | ((w & 64'd1) << (n - 1))) & mask;
				res.word = w >> r;
				res.outcome = cscodec_pkg::STATUS_CORRECTED;
				return res;
			end
			w = ((w << 1) | (w >> (n - 1))) & mask;
			syn = gf2_remainder(w, n, r, g);
		end
		res.outcome = cscodec_pkg::STATUS_UNCORRECTABLE;
		return res;
	endfunction

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin : check_results
		codec_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: word %h status %0d",
					$time, word_out, status);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (word_out !== want.word) begin
					$display("%0t: word_out expected %h actual %h", $time, want.word, word_out);
					mismatch_count++;
				end
				if (status !== want.outcome) begin
					$display("%0t: status expected %0d actual %0d", $time, want.outcome, status);
					mismatch_count++;
				end
			end
		end
	end

	// Offer one item, sometimes after random idle cycles, and wait until it is taken.
	task automatic send_item(logic op, logic [MAX_CODE_BITS-1:0] w);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < sender_idle_pct / 4) gap = $urandom_range(1, 130);
		while ($urandom_range(0, 99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		word_in <= w;
		do @(posedge clk); while (busy !== 1'b0);
		expected_results.push_back(predict_codec_result(active_cfg, op, w));
	endtask

	// Stop sending and wait until every result has arrived.
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0 || busy !== 1'b0);
		repeat (2) @(posedge clk);
	endtask

	// Bus write: setup cycle, access cycle until pready, then idle.
	task automatic write_reg(cscodec_pkg::reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			cscodec_pkg::REG_GEN: active_cfg.gen = value[GEN_W-1:0];
			cscodec_pkg::REG_CHK: active_cfg.chk = value[CHK_W-1:0];
			cscodec_pkg::REG_MSG: active_cfg.msg = value[MSG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_config(logic [DATA_W-1:0] gen, logic [DATA_W-1:0] chk,
			logic [DATA_W-1:0] msg);
		wait_idle();
		write_reg(cscodec_pkg::REG_GEN, gen);
		write_reg(cscodec_pkg::REG_CHK, chk);
		write_reg(cscodec_pkg::REG_MSG, msg);
	endtask

	// The (7,4) code left by reset: clean words, every single error, a double error.
	task automatic test_hamming_basics();
		logic [MAX_CODE_BITS-1:0] cw;
		codec_result_t            res;
		send_item(cscodec_pkg::KIND_ENCODE, '0);
		send_item(cscodec_pkg::KIND_ENCODE, '1);
		send_item(cscodec_pkg::KIND_ENCODE, 64'hB);
		res = predict_codec_result(active_cfg, cscodec_pkg::KIND_ENCODE, 64'hB);
		cw = res.word;
		send_item(cscodec_pkg::KIND_DECODE, cw);
		for (int i = 0; i < 7; i++)
			send_item(cscodec_pkg::KIND_DECODE, cw ^ (64'd1 << i));
		send_item(cscodec_pkg::KIND_DECODE, cw ^ 64'h5);
		send_item(cscodec_pkg::KIND_DECODE, '1);
	endtask

	// Clamped sizes, generator bits beyond the degree, and a word that cannot be trapped.
	task automatic test_size_limits();
		logic [MAX_CODE_BITS-1:0] cw;
		codec_result_t            res;
		write_config(32'h1FF, 32'd0, 32'd0);
		send_item(cscodec_pkg::KIND_ENCODE, '1);
		send_item(cscodec_pkg::KIND_DECODE, 64'h1);
		write_config(32'h1FF, 32'd15, 32'd63);
		send_item(cscodec_pkg::KIND_ENCODE, '1);
		res = predict_codec_result(active_cfg, cscodec_pkg::KIND_ENCODE, '1);
		cw = res.word;
		send_item(cscodec_pkg::KIND_DECODE, cw ^ (64'd1 << 63));
		write_config(32'h10, 32'd4, 32'd4);
		send_item(cscodec_pkg::KIND_DECODE, 64'hFF);
		send_item(cscodec_pkg::KIND_DECODE, 64'h04);
	endtask

	// Mostly encoded words with zero, one or two flipped bits, plus raw noise.
	task automatic test_random_traffic();
		int                       idle_pct[3];
		int                       r;
		int                       k;
		int                       n;
		int                       pick;
		logic                     op;
		logic [MAX_CODE_BITS-1:0] noise;
		logic [MAX_CODE_BITS-1:0] w;
		codec_result_t            res;
		idle_pct = '{23, 51, 0};
		for (int p = 0; p < 3; p++) begin
			sender_idle_pct = idle_pct[p];
			for (int c = 0; c < 7; c++) begin
				case (c)
					0: write_config(32'h00B, 32'd3, 32'd4);
					1: write_config(32'h013, 32'd4, 32'd11);
					2: write_config(32'h107, 32'd8, 32'd56);
					3: write_config(32'h003, 32'd1, 32'd63);
					4: write_config(32'h1D1, 32'd8, 32'd7);
					default: write_config($urandom, $urandom, $urandom);
				endcase
				clamp_sizes(active_cfg, r, k);
				n = r + k;
				repeat (24) begin
					// Now and then hold off until the block has drained.
					if ($urandom_range(0, 39) == 0) wait_idle();
					op = 1'($urandom_range(0, 1));
					noise = {$urandom, $urandom};
					pick = $urandom_range(0, 99);
					if (op == cscodec_pkg::KIND_ENCODE) begin
						w = (pick < 25) ? noise : (noise & ones_below(k));
					end else if (pick < 10) begin
						w = noise;
					end else begin
						res = predict_codec_result(active_cfg, cscodec_pkg::KIND_ENCODE, noise);
						w = res.word;
						if (pick >= 40) w[$urandom_range(0, n - 1)] ^= 1'b1;
						if (pick >= 75) w[$urandom_range(0, n - 1)] ^= 1'b1;
						if ($urandom_range(0, 3) == 0) w |= {$urandom, $urandom} & ~ones_below(n);
					end
					send_item(op, w);
				end
			end
		end
	endtask

	initial begin
		start <= 1'b0;
		kind <= cscodec_pkg::KIND_ENCODE;
		word_in <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hamming_basics();
		test_size_limits();
		test_random_traffic();
		wait_idle();
		repeat (140) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
